// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    // Width of the edge delay counter.
    localparam int COUNTER_WIDTH = 16;

    localparam int CFG_W = 16;

    // Largest value the delay counter can hold, kept one bit wider than any legal width.
    localparam logic [32:0] CNT_MAX = (33'd1 << COUNTER_WIDTH) - 33'd1;

    // Configuration register indexes.
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd24;
    localparam logic [CFG_W-1:0] ACK_TIMEOUT_RESET = 16'd1000;

    // Command codes.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_STOP    = 3'd2;
    localparam logic [2:0] KIND_WRITE   = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;
    localparam logic [2:0] KIND_RECOVER = 3'd5;

    // Status codes.
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_INVALID_ARG = 2'd2;
    localparam logic [1:0] STAT_BUS_STUCK   = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] wr_data;
        logic       ack_after_read;
        logic [7:0] pulse_count;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rd_data;
    } t_result;

endpackage

// ===== rtl/i2cm_engine.sv =====
`timescale 1ns / 1ps

module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_item            i_item,
    input  logic [CFG_W-1:0] i_half_period,
    input  logic [CFG_W-1:0] i_ack_timeout,
    output t_result          o_res
);

    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_ST_A     = 5'd1;
    localparam logic [4:0] PH_ST_B     = 5'd2;
    localparam logic [4:0] PH_SP_A     = 5'd3;
    localparam logic [4:0] PH_SP_B     = 5'd4;
    localparam logic [4:0] PH_SP_C     = 5'd5;
    localparam logic [4:0] PH_WR_HI    = 5'd6;
    localparam logic [4:0] PH_WR_LO    = 5'd7;
    localparam logic [4:0] PH_AK_FIRST = 5'd8;
    localparam logic [4:0] PH_AK_WAIT  = 5'd9;
    localparam logic [4:0] PH_RD_SAMP  = 5'd10;
    localparam logic [4:0] PH_RD_NEXT  = 5'd11;
    localparam logic [4:0] PH_RK_HI    = 5'd12;
    localparam logic [4:0] PH_RK_LO    = 5'd13;
    localparam logic [4:0] PH_RC_HI    = 5'd14;
    localparam logic [4:0] PH_RC_SAMP  = 5'd15;

    logic [4:0]               r_phase, n_phase;
    logic [3:0]               r_bit_count, n_bit_count;
    logic [7:0]               r_shift, n_shift;
    logic [COUNTER_WIDTH-1:0] r_delay, n_delay;
    logic [15:0]              r_timeout, n_timeout;
    logic [7:0]               r_pulses, n_pulses;
    logic                     r_scl, n_scl;
    logic                     r_sda, n_sda;
    logic                     r_ack_flag, n_ack_flag;
    logic [1:0]               r_status, n_status;
    logic [7:0]               r_rd_latch, n_rd_latch;
    logic                     r_stop_check, n_stop_check;
    logic                     n_done;

    logic [CFG_W-1:0]         w_hp_m1;
    logic [32:0]              w_hp_wide;
    logic [COUNTER_WIDTH-1:0] w_dload;

    // Reload value for the edge delay: half_period minus one, zero treated as one,
    // clipped to what the counter holds.
    always_comb begin
        w_hp_m1   = (i_half_period == '0) ? '0 : i_half_period - 1'b1;
        w_hp_wide = {{(33 - CFG_W){1'b0}}, w_hp_m1};
        if (w_hp_wide > CNT_MAX) begin
            w_dload = CNT_MAX[COUNTER_WIDTH-1:0];
        end else begin
            w_dload = w_hp_wide[COUNTER_WIDTH-1:0];
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_timeout    = r_timeout;
        n_pulses     = r_pulses;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_flag   = r_ack_flag;
        n_status     = r_status;
        n_rd_latch   = r_rd_latch;
        n_stop_check = r_stop_check;
        n_done       = 1'b0;

        if (r_phase == PH_IDLE) begin
            case (i_item.kind)
                KIND_START: begin
                    n_status = STAT_OK;
                    n_sda    = 1'b1;
                    n_scl    = 1'b1;
                    n_phase  = PH_ST_A;
                    n_delay  = w_dload;
                end
                KIND_STOP: begin
                    n_status     = STAT_OK;
                    n_scl        = 1'b0;
                    n_sda        = 1'b0;
                    n_stop_check = 1'b0;
                    n_phase      = PH_SP_A;
                    n_delay      = w_dload;
                end
                KIND_WRITE: begin
                    n_status    = STAT_OK;
                    n_shift     = i_item.wr_data;
                    n_bit_count = 4'd8;
                    n_sda       = i_item.wr_data[7];
                    n_phase     = PH_WR_HI;
                    n_delay     = w_dload;
                end
                KIND_READ: begin
                    n_status    = STAT_OK;
                    n_shift     = '0;
                    n_bit_count = 4'd8;
                    n_ack_flag  = i_item.ack_after_read;
                    n_sda       = 1'b1;
                    n_scl       = 1'b1;
                    n_phase     = PH_RD_SAMP;
                    n_delay     = w_dload;
                end
                KIND_RECOVER: begin
                    if (i_item.pulse_count == '0) begin
                        n_status = STAT_INVALID_ARG;
                        n_done   = 1'b1;
                    end else begin
                        n_status = STAT_OK;
                        n_pulses = i_item.pulse_count;
                        n_sda    = 1'b1;
                        n_scl    = 1'b0;
                        n_phase  = PH_RC_HI;
                        n_delay  = w_dload;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_delay != '0) begin
            n_delay = r_delay - 1'b1;
        end else begin
            case (r_phase)
                PH_ST_A: begin
                    n_sda   = 1'b0;
                    n_phase = PH_ST_B;
                    n_delay = w_dload;
                end
                PH_ST_B: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                PH_SP_A: begin
                    n_scl   = 1'b1;
                    n_phase = PH_SP_B;
                    n_delay = w_dload;
                end
                PH_SP_B: begin
                    n_sda   = 1'b1;
                    n_phase = PH_SP_C;
                    n_delay = w_dload;
                end
                PH_SP_C: begin
                    if (r_stop_check) begin
                        n_status = i_item.sda_in ? STAT_OK : STAT_BUS_STUCK;
                    end
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                PH_WR_HI: begin
                    n_scl   = 1'b1;
                    n_phase = PH_WR_LO;
                    n_delay = w_dload;
                end
                PH_WR_LO: begin
                    n_scl       = 1'b0;
                    n_bit_count = r_bit_count - 1'b1;
                    n_delay     = w_dload;
                    if (n_bit_count != '0) begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_sda   = r_shift[6];
                        n_phase = PH_WR_HI;
                    end else begin
                        n_sda   = 1'b1;
                        n_phase = PH_AK_FIRST;
                    end
                end
                PH_AK_FIRST: begin
                    if (!i_item.sda_in) begin
                        n_scl   = 1'b0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_scl     = 1'b1;
                        n_timeout = i_ack_timeout;
                        n_phase   = PH_AK_WAIT;
                        n_delay   = w_dload;
                    end
                end
                PH_AK_WAIT: begin
                    if (r_timeout == '0) begin
                        n_status     = STAT_ACK_TIMEOUT;
                        n_scl        = 1'b0;
                        n_sda        = 1'b0;
                        n_stop_check = 1'b0;
                        n_phase      = PH_SP_A;
                        n_delay      = w_dload;
                    end else begin
                        n_timeout = r_timeout - 1'b1;
                        if (!i_item.sda_in) begin
                            n_scl   = 1'b0;
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_phase = PH_AK_WAIT;
                            n_delay = w_dload;
                        end
                    end
                end
                PH_RD_SAMP: begin
                    n_shift     = {r_shift[6:0], i_item.sda_in};
                    n_scl       = 1'b0;
                    n_bit_count = r_bit_count - 1'b1;
                    n_phase     = PH_RD_NEXT;
                    n_delay     = w_dload;
                end
                PH_RD_NEXT: begin
                    n_delay = w_dload;
                    if (r_bit_count != '0) begin
                        n_scl   = 1'b1;
                        n_phase = PH_RD_SAMP;
                    end else begin
                        n_sda   = ~r_ack_flag;
                        n_phase = PH_RK_HI;
                    end
                end
                PH_RK_HI: begin
                    n_scl   = 1'b1;
                    n_phase = PH_RK_LO;
                    n_delay = w_dload;
                end
                PH_RK_LO: begin
                    n_scl      = 1'b0;
                    n_sda      = 1'b1;
                    n_rd_latch = r_shift;
                    n_phase    = PH_IDLE;
                    n_done     = 1'b1;
                end
                PH_RC_HI: begin
                    n_scl   = 1'b1;
                    n_phase = PH_RC_SAMP;
                    n_delay = w_dload;
                end
                PH_RC_SAMP: begin
                    n_pulses = r_pulses - 1'b1;
                    n_delay  = w_dload;
                    if (i_item.sda_in) begin
                        // Bus freed: stop without a final check.
                        n_pulses     = r_pulses;
                        n_scl        = 1'b0;
                        n_sda        = 1'b0;
                        n_stop_check = 1'b0;
                        n_phase      = PH_SP_A;
                    end else if (n_pulses != '0) begin
                        n_scl   = 1'b0;
                        n_phase = PH_RC_HI;
                    end else begin
                        n_scl        = 1'b0;
                        n_sda        = 1'b0;
                        n_stop_check = 1'b1;
                        n_phase      = PH_SP_A;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_delay      <= '0;
            r_timeout    <= '0;
            r_pulses     <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_flag   <= 1'b0;
            r_status     <= STAT_OK;
            r_rd_latch   <= '0;
            r_stop_check <= 1'b0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_timeout    <= n_timeout;
            r_pulses     <= n_pulses;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_ack_flag   <= n_ack_flag;
            r_status     <= n_status;
            r_rd_latch   <= n_rd_latch;
            r_stop_check <= n_stop_check;
        end
    end

    always_comb begin
        o_res.scl_out  = n_scl;
        o_res.sda_out  = n_sda;
        o_res.busy_res = (n_phase != PH_IDLE);
        o_res.done_res = n_done;
        o_res.status   = n_status;
        o_res.rd_data  = n_rd_latch;
    end

endmodule

// ===== rtl/i2c_bit_level_master_core.sv =====
`timescale 1ns / 1ps

// Bit-level I2C master. Each input beat is one tick of the bus timing: it carries the
// sampled SDA level and, when the master is idle, an optional command (start, stop,
// write byte, read byte, bus recovery). Each input beat yields exactly one result beat
// with the SCL and SDA drives after that tick, busy, a done pulse, the status of the
// last command and the last byte read. Commands given while busy are ignored. The
// block takes one beat per clock cycle while the output is not stalled; a beat passes
// an input register, the state update logic and an output register, which holds its
// result until it is taken. The rate is set by the bus state machine, which updates
// once per beat. half_period and ack_timeout are written through the configuration
// port; the user must write them only while the master is idle and no beats are in
// flight, as the block itself does not enforce this.

module i2c_bit_level_master_core
    import i2cm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,

    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_kind,
    input  logic [7:0]       i_wr_data,
    input  logic             i_ack_after_read,
    input  logic [7:0]       i_pulse_count,
    input  logic             i_sda_in,

    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_scl_out,
    output logic             o_sda_out,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [1:0]       o_status,
    output logic [7:0]       o_rd_data
);

    logic [CFG_W-1:0] r_half_period;
    logic [CFG_W-1:0] r_ack_timeout;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result w_res;

    logic w_in_take;
    logic w_advance;
    logic w_out_take;

    // The engine steps on the held beat whenever the output register is free or
    // its beat leaves in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign w_out_take = r_out_valid && !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HALF_PERIOD: r_half_period <= i_cfg_data;
                REG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.kind           <= i_kind;
            r_in.wr_data        <= i_wr_data;
            r_in.ack_after_read <= i_ack_after_read;
            r_in.pulse_count    <= i_pulse_count;
            r_in.sda_in         <= i_sda_in;
        end
    end

    i2cm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_advance),
        .i_item        (r_in),
        .i_half_period (r_half_period),
        .i_ack_timeout (r_ack_timeout),
        .o_res         (w_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_out.scl_out;
    assign o_sda_out   = r_out.sda_out;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_status    = r_out.status;
    assign o_rd_data   = r_out.rd_data;

endmodule

// ===== rtl/i2cm_checker.sv =====
`timescale 1ns / 1ps

module i2cm_checker
    import i2cm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_scl_out,
    input logic             o_sda_out,
    input logic             o_busy_res,
    input logic             o_done_res,
    input logic [1:0]       o_status,
    input logic [7:0]       o_rd_data
);

    // A finished command always leaves the master idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    // With the output register empty the input side never backs up.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output register is empty");

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rd_data)
            && $stable(o_status) && $stable(o_scl_out) && $stable(o_sda_out))
        else $error("stalled result beat changed");

endmodule

bind i2c_bit_level_master_core i2cm_checker u_i2cm_checker (.*);
